>>> hw/rtl/bba_pkg.sv
package bba_pkg;

	localparam int DEF_MAX_LEVEL = 16;
	localparam int MIN_LEVEL     = 5;
	localparam int HEADER_BYTES  = 8;
	localparam int MIN_NEED      = 24;

	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	localparam logic STAT_OK  = 1'b0;
	localparam logic STAT_OOM = 1'b1;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ASCAN,
		S_UL_WR,
		S_SPLIT,
		S_PUSH,
		S_PUSH_RD,
		S_PUSH_FIN,
		S_FR_RD,
		S_FR_LV,
		S_FR_CHK,
		S_MG,
		S_MG_CK,
		S_FIN,
		S_DONE
	} state_t;

endpackage

>>> hw/rtl/bba_ram.sv
module bba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> hw/rtl/buddy_block_allocator.sv
// allocate: scans the levels upward for a free block, then splits it down to the requested level
// an oversized allocate goes straight to the result; a double free ends before any merge
// free: reads the stored level, checks the block, then merges with its buddy one level at a time
// one item at a time; the pace is set by the walk over levels through the link and metadata RAMs
// in_ready is high only while idle; a result waits in the output register
// reset: asynchronous, active low; only the top level list holds block 0, no clearing pass
module buddy_block_allocator #(
	parameter int MAX_LEVEL = bba_pkg::DEF_MAX_LEVEL
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [15:0] request_size,
	input  logic [15:0] free_offset,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        status,
	output logic [15:0] data_offset
);
	import bba_pkg::*;

	localparam int AW    = MAX_LEVEL;
	localparam int SW    = MAX_LEVEL - MIN_LEVEL;
	localparam int NS    = 1 << SW;
	localparam int HD    = MAX_LEVEL + 1;
	localparam int HIW   = $clog2(HD);
	localparam int LVL_W = $clog2(MAX_LEVEL + 2);
	localparam int MW    = LVL_W + 1;

	state_t state_q, state_d;

	logic             cmd_q, cmd_d;
	logic             oom_q, oom_d;
	logic [LVL_W-1:0] req_q, req_d;
	logic [LVL_W-1:0] lvl_q, lvl_d;
	logic [SW-1:0]    blk_q, blk_d;
	logic [SW-1:0]    s_q, s_d;
	logic [SW-1:0]    t_q, t_d;
	logic [HD-1:0]    mask_q, mask_d;
	logic [SW-1:0]    head_q [HD];
	logic             head_we;
	logic [SW-1:0]    head_wd;
	logic             init0_q, meta_z_q;
	logic             out_valid_q, status_q;
	logic [15:0]      data_offset_q;
	logic             out_load;
	logic             res_status;
	logic [15:0]      res_offset;

	// ram ports
	logic          meta_we, nxt_we, prv_we;
	logic [SW-1:0] meta_wa, meta_ra, nxt_wa, nxt_ra, prv_wa, prv_ra;
	logic [MW-1:0] meta_wd, meta_rd, meta_eff;
	logic [SW-1:0] nxt_wd, nxt_rd, prv_wd, prv_rd;
	logic [SW-1:0] nxt_eff, prv_eff;

	// request decode
	logic [16:0]      need;
	logic [4:0]       req5;
	logic [31:0]      fo32;
	logic [AW-1:0]    fstart;
	logic [SW-1:0]    cur_head;
	logic             cur_ne;
	logic [SW-1:0]    stride;
	logic [SW-1:0]    stride_m1;
	logic [LVL_W-1:0] lvl_m1;
	logic [LVL_W-1:0] meta_lvl;
	logic [LVL_W-1:0] clamp_lvl;
	logic [SW-1:0]    clamp_stride;
	logic [31:0]      blk32;

	bba_ram #(.WIDTH(MW), .DEPTH(NS)) u_meta (
		.clk(clk), .we(meta_we), .waddr(meta_wa), .wdata(meta_wd),
		.raddr(meta_ra), .rdata(meta_rd)
	);
	bba_ram #(.WIDTH(SW), .DEPTH(NS)) u_next (
		.clk(clk), .we(nxt_we), .waddr(nxt_wa), .wdata(nxt_wd),
		.raddr(nxt_ra), .rdata(nxt_rd)
	);
	bba_ram #(.WIDTH(SW), .DEPTH(NS)) u_prev (
		.clk(clk), .we(prv_we), .waddr(prv_wa), .wdata(prv_wd),
		.raddr(prv_ra), .rdata(prv_rd)
	);

	// slot 0 reads as a free top level block until first written
	assign meta_eff = (meta_z_q && init0_q) ? {1'b1, LVL_W'(MAX_LEVEL)} : meta_rd;
	assign meta_lvl = meta_eff[LVL_W-1:0];

	// slot 0 links form a one entry list until block 0 is first taken
	assign nxt_eff = (init0_q && s_q == '0) ? '0 : nxt_rd;
	assign prv_eff = (init0_q && s_q == '0) ? '0 : prv_rd;

	// required level from the byte count
	always_comb begin
		need = {1'b0, request_size} + 17'(HEADER_BYTES);
		if (need < 17'(MIN_NEED)) begin
			need = 17'(MIN_NEED);
		end
		req5 = 5'(MIN_LEVEL);
		for (int i = MIN_LEVEL; i <= 16; i++) begin
			if ((17'(1) << i) < need) begin
				req5 = 5'(i + 1);
			end
		end
	end

	assign fo32      = {16'b0, free_offset};
	assign fstart    = fo32[AW-1:0] - AW'(HEADER_BYTES);
	assign cur_head  = head_q[lvl_q[HIW-1:0]];
	assign cur_ne    = mask_q[lvl_q[HIW-1:0]];
	assign lvl_m1    = lvl_q - LVL_W'(1);
	assign stride    = SW'(1) << (lvl_q - LVL_W'(MIN_LEVEL));
	assign stride_m1 = SW'(1) << (lvl_m1 - LVL_W'(MIN_LEVEL));

	// stored level clamped into the legal range
	always_comb begin
		clamp_lvl = meta_lvl;
		if (meta_lvl < LVL_W'(MIN_LEVEL)) begin
			clamp_lvl = LVL_W'(MIN_LEVEL);
		end
		if (meta_lvl > LVL_W'(MAX_LEVEL)) begin
			clamp_lvl = LVL_W'(MAX_LEVEL);
		end
		clamp_stride = SW'(1) << (clamp_lvl - LVL_W'(MIN_LEVEL));
	end

	// result of the finished item
	assign blk32      = 32'(blk_q) << MIN_LEVEL;
	assign res_status = (cmd_q == CMD_ALLOC) ? oom_q : STAT_OK;
	assign res_offset = (cmd_q == CMD_ALLOC && oom_q == STAT_OK) ?
		blk32[15:0] + 16'(HEADER_BYTES) : 16'd0;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// sequencer: next state, ram ports and register updates
	always_comb begin
		state_d  = state_q;
		cmd_d    = cmd_q;
		oom_d    = oom_q;
		req_d    = req_q;
		lvl_d    = lvl_q;
		blk_d    = blk_q;
		s_d      = s_q;
		t_d      = t_q;
		mask_d   = mask_q;
		head_we  = 1'b0;
		head_wd  = s_q;
		meta_we  = 1'b0;
		meta_wa  = blk_q;
		meta_wd  = {1'b1, lvl_q};
		meta_ra  = blk_q;
		nxt_we   = 1'b0;
		nxt_wa   = s_q;
		nxt_wd   = s_q;
		nxt_ra   = s_q;
		prv_we   = 1'b0;
		prv_wa   = s_q;
		prv_wd   = s_q;
		prv_ra   = s_q;
		out_load = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd_d = cmd;
					oom_d = STAT_OK;
					req_d = req5[LVL_W-1:0];
					lvl_d = req5[LVL_W-1:0];
					blk_d = fstart[AW-1:MIN_LEVEL];
					if (cmd == CMD_FREE) begin
						state_d = S_FR_RD;
					end else if ({27'b0, req5} > 32'(MAX_LEVEL)) begin
						oom_d   = STAT_OOM;
						state_d = S_DONE;
					end else begin
						state_d = S_ASCAN;
					end
				end
			end
			S_ASCAN: begin
				if (cur_ne) begin
					blk_d   = cur_head;
					s_d     = cur_head;
					nxt_ra  = cur_head;
					prv_ra  = cur_head;
					state_d = S_UL_WR;
				end else if (lvl_q == LVL_W'(MAX_LEVEL)) begin
					oom_d   = STAT_OOM;
					state_d = S_DONE;
				end else begin
					lvl_d = lvl_q + LVL_W'(1);
				end
			end
			S_UL_WR: begin
				if (nxt_eff == s_q) begin
					mask_d[lvl_q[HIW-1:0]] = 1'b0;
				end else begin
					nxt_we = 1'b1;
					nxt_wa = prv_eff;
					nxt_wd = nxt_eff;
					prv_we = 1'b1;
					prv_wa = nxt_eff;
					prv_wd = prv_eff;
					if (cur_head == s_q) begin
						head_we = 1'b1;
						head_wd = nxt_eff;
					end
				end
				if (cmd_q == CMD_ALLOC) begin
					state_d = S_SPLIT;
				end else begin
					blk_d   = blk_q & ~stride;
					lvl_d   = lvl_q + LVL_W'(1);
					state_d = S_MG;
				end
			end
			S_SPLIT: begin
				if (lvl_q > req_q) begin
					lvl_d   = lvl_m1;
					s_d     = blk_q + stride_m1;
					meta_we = 1'b1;
					meta_wa = blk_q + stride_m1;
					meta_wd = {1'b1, lvl_m1};
					state_d = S_PUSH;
				end else begin
					meta_we = 1'b1;
					meta_wa = blk_q;
					meta_wd = {1'b0, req_q};
					state_d = S_DONE;
				end
			end
			S_PUSH: begin
				if (!cur_ne) begin
					nxt_we  = 1'b1;
					prv_we  = 1'b1;
					head_we = 1'b1;
					mask_d[lvl_q[HIW-1:0]] = 1'b1;
					state_d = (cmd_q == CMD_ALLOC) ? S_SPLIT : S_DONE;
				end else begin
					prv_ra  = cur_head;
					state_d = S_PUSH_RD;
				end
			end
			S_PUSH_RD: begin
				t_d     = prv_rd;
				nxt_we  = 1'b1;
				nxt_wd  = cur_head;
				prv_we  = 1'b1;
				prv_wd  = prv_rd;
				state_d = S_PUSH_FIN;
			end
			S_PUSH_FIN: begin
				nxt_we  = 1'b1;
				nxt_wa  = t_q;
				prv_we  = 1'b1;
				prv_wa  = cur_head;
				head_we = 1'b1;
				mask_d[lvl_q[HIW-1:0]] = 1'b1;
				state_d = (cmd_q == CMD_ALLOC) ? S_SPLIT : S_DONE;
			end
			S_FR_RD: begin
				state_d = S_FR_LV;
			end
			S_FR_LV: begin
				lvl_d   = clamp_lvl;
				blk_d   = blk_q & ~(clamp_stride - SW'(1));
				meta_ra = blk_q & ~(clamp_stride - SW'(1));
				state_d = S_FR_CHK;
			end
			S_FR_CHK: begin
				state_d = meta_eff[LVL_W] ? S_DONE : S_MG;
			end
			S_MG: begin
				if (lvl_q == LVL_W'(MAX_LEVEL)) begin
					state_d = S_FIN;
				end else begin
					s_d     = blk_q ^ stride;
					meta_ra = blk_q ^ stride;
					state_d = S_MG_CK;
				end
			end
			S_MG_CK: begin
				if (meta_lvl != lvl_q || !meta_eff[LVL_W]) begin
					state_d = S_FIN;
				end else begin
					state_d = S_UL_WR;
				end
			end
			S_FIN: begin
				meta_we = 1'b1;
				meta_wa = blk_q;
				meta_wd = {1'b1, lvl_q};
				s_d     = blk_q;
				state_d = S_PUSH;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= HD'(1) << MAX_LEVEL;
			init0_q     <= 1'b1;
			out_valid_q <= 1'b0;
			for (int i = 0; i < HD; i++) begin
				head_q[i] <= '0;
			end
		end else begin
			mask_q <= mask_d;
			if (head_we) begin
				head_q[lvl_q[HIW-1:0]] <= head_wd;
			end
			if (meta_we && meta_wa == '0) begin
				init0_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working and output payload registers
	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		oom_q    <= oom_d;
		req_q    <= req_d;
		lvl_q    <= lvl_d;
		blk_q    <= blk_d;
		s_q      <= s_d;
		t_q      <= t_d;
		meta_z_q <= (meta_ra == '0);
		if (out_load) begin
			status_q      <= res_status;
			data_offset_q <= res_offset;
		end
	end

	assign in_ready    = (state_q == S_IDLE);
	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign data_offset = data_offset_q;

	// a failed allocate never returns an offset
	a_oom_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == STAT_OOM) |-> data_offset == 16'd0)
		else $error("offset returned with out of memory");

	// every offset is zero or a slot start plus the header
	a_ofs_align: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (data_offset == 16'd0 || data_offset[4:0] == 5'(HEADER_BYTES)))
		else $error("misaligned data offset");

	// the block is busy right after taking an item
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("ready right after accept");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
	import bba_pkg::*;

	localparam int TOP_LVL    = DEF_MAX_LEVEL;
	localparam int NUM_SLOTS  = 1 << (TOP_LVL - MIN_LEVEL);
	localparam int NO_BLOCK   = NUM_SLOTS;
	localparam int WDOG_LIMIT = 5000;
	localparam int HOLD_LEN   = 400;

	typedef struct {
		logic        cmd;
		logic [15:0] size;
		logic [15:0] offset;
		bit          drain_first;
		int          gap;
	} alloc_req_t;

	typedef struct {
		logic        status;
		logic [15:0] data_offset;
	} alloc_resp_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        cmd;
	logic [15:0] request_size;
	logic [15:0] free_offset;
	logic        out_valid;
	logic        out_ready;
	logic        status;
	logic [15:0] data_offset;

	alloc_req_t  pending_reqs[$];
	alloc_resp_t expected_resps[$];
	int          fail_count;
	int          sent_count;
	int          recv_count;
	bit          gen_done;
	bit          in_taken;

	// allocator shadow state
	logic [16:0] nonempty_mask;
	logic [4:0]  slot_level[NUM_SLOTS];
	bit          slot_free[NUM_SLOTS];
	bit          slot_known[NUM_SLOTS];
	logic [10:0] link_prev[NUM_SLOTS];
	logic [10:0] link_next[NUM_SLOTS];
	int          level_head[TOP_LVL + 1];
	logic [15:0] live_offsets[$];

	buddy_block_allocator DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .request_size(request_size), .free_offset(free_offset),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .data_offset(data_offset)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	function automatic void set_slot(int s, int lvl, bit fr);
		slot_level[s] = lvl[4:0];
		slot_free[s]  = fr;
		slot_known[s] = 1'b1;
	endfunction

	function automatic void list_push(int lvl, int s);
		int h, t;
		h = level_head[lvl];
		if (h == NO_BLOCK) begin
			link_next[s] = s[10:0];
			link_prev[s] = s[10:0];
		end else begin
			t = link_prev[h];
			link_next[s] = h[10:0];
			link_prev[s] = t[10:0];
			link_next[t] = s[10:0];
			link_prev[h] = s[10:0];
		end
		level_head[lvl] = s;
		nonempty_mask[lvl] = 1'b1;
	endfunction

	function automatic void list_unlink(int lvl, int s);
		int n, p;
		n = link_next[s];
		p = link_prev[s];
		if (n == s) begin
			level_head[lvl] = NO_BLOCK;
			nonempty_mask[lvl] = 1'b0;
		end else begin
			link_next[p] = n[10:0];
			link_prev[n] = p[10:0];
			if (level_head[lvl] == s)
				level_head[lvl] = n;
		end
	endfunction

	// compute the response of one item and update the shadow state
	function automatic alloc_resp_t predict_alloc(alloc_req_t r);
		alloc_resp_t rsp;
		int need, want, lvl, blk, bud, start, idx, nb;
		rsp.status = STAT_OK;
		rsp.data_offset = '0;
		if (r.cmd == CMD_ALLOC) begin
			need = int'(r.size) + HEADER_BYTES;
			if (need < MIN_NEED)
				need = MIN_NEED;
			want = MIN_LEVEL;
			while (want < 31 && (1 << want) < need)
				want++;
			lvl = want;
			while (lvl <= TOP_LVL && !nonempty_mask[lvl])
				lvl++;
			if (lvl > TOP_LVL || level_head[lvl] == NO_BLOCK) begin
				rsp.status = STAT_OOM;
				return rsp;
			end
			blk = level_head[lvl];
			list_unlink(lvl, blk);
			// split down, upper halves go back on the free lists
			while (lvl > want) begin
				lvl--;
				bud = (blk + (1 << (lvl - MIN_LEVEL))) & (NUM_SLOTS - 1);
				set_slot(bud, lvl, 1'b1);
				list_push(lvl, bud);
			end
			set_slot(blk, want, 1'b0);
			rsp.data_offset = 16'((blk << MIN_LEVEL) + HEADER_BYTES);
		end else begin
			start = int'(16'(r.offset - 16'(HEADER_BYTES)));
			lvl = slot_level[start >> MIN_LEVEL];
			if (lvl < MIN_LEVEL)
				lvl = MIN_LEVEL;
			if (lvl > TOP_LVL)
				lvl = TOP_LVL;
			idx = start >> lvl;
			blk = ((idx << lvl) >> MIN_LEVEL) & (NUM_SLOTS - 1);
			if (slot_free[blk])
				return rsp;
			// merge with free buddies of equal level
			while (lvl < TOP_LVL) begin
				nb = (((idx ^ 1) << lvl) >> MIN_LEVEL) & (NUM_SLOTS - 1);
				if (slot_level[nb] != lvl || !slot_free[nb])
					break;
				list_unlink(lvl, nb);
				idx = idx >> 1;
				lvl++;
			end
			blk = ((idx << lvl) >> MIN_LEVEL) & (NUM_SLOTS - 1);
			set_slot(blk, lvl, 1'b1);
			list_push(lvl, blk);
		end
		return rsp;
	endfunction

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 65)
			return 0;
		if (p < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic queue_item(logic c, logic [15:0] sz, logic [15:0] off, bit drain);
		alloc_req_t r;
		alloc_resp_t rsp;
		r.cmd = c;
		r.size = sz;
		r.offset = off;
		r.drain_first = drain;
		r.gap = pick_gap();
		rsp = predict_alloc(r);
		if (c == CMD_ALLOC && rsp.status == STAT_OK)
			live_offsets.push_back(rsp.data_offset);
		pending_reqs.push_back(r);
		expected_resps.push_back(rsp);
	endtask

	function automatic logic [15:0] known_slot_offset();
		int s;
		s = $urandom_range(0, NUM_SLOTS - 1);
		while (!slot_known[s])
			s = $urandom_range(0, NUM_SLOTS - 1);
		return 16'((s << MIN_LEVEL) + $urandom_range(0, 31) + HEADER_BYTES);
	endfunction

	function automatic logic [15:0] rand_size();
		int p;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 16'($urandom_range(0, 120));
		if (p < 90)
			return 16'($urandom_range(0, 2000));
		return 16'($urandom);
	endfunction

	// stimulus and expected responses
	initial begin
		int p, k;
		logic [15:0] off;
		nonempty_mask = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			slot_level[i] = '0;
			slot_free[i]  = 1'b0;
			slot_known[i] = 1'b0;
			link_prev[i]  = '0;
			link_next[i]  = '0;
		end
		for (int i = 0; i <= TOP_LVL; i++)
			level_head[i] = NO_BLOCK;
		set_slot(0, TOP_LVL, 1'b1);
		list_push(TOP_LVL, 0);

		// directed: whole arena, out of memory, double free, inner offsets
		queue_item(CMD_ALLOC, 16'd65528, 16'hffff, 1'b0);
		queue_item(CMD_ALLOC, 16'd0, 16'h0000, 1'b0);
		queue_item(CMD_ALLOC, 16'd65535, 16'h0000, 1'b0);
		queue_item(CMD_FREE, 16'hffff, 16'd8, 1'b0);
		queue_item(CMD_FREE, 16'h0000, 16'd8, 1'b0);
		queue_item(CMD_ALLOC, 16'd65535, 16'h0000, 1'b0);
		queue_item(CMD_ALLOC, 16'd0, 16'h0000, 1'b0);
		queue_item(CMD_ALLOC, 16'd16, 16'h0000, 1'b0);
		queue_item(CMD_ALLOC, 16'd17, 16'h0000, 1'b0);
		queue_item(CMD_ALLOC, 16'd24, 16'h0000, 1'b0);
		queue_item(CMD_ALLOC, 16'd1000, 16'h0000, 1'b0);
		queue_item(CMD_ALLOC, 16'd32760, 16'h0000, 1'b0);
		queue_item(CMD_ALLOC, 16'd32761, 16'h0000, 1'b0);
		queue_item(CMD_FREE, 16'h0000, 16'd8 + 16'd40, 1'b0);
		queue_item(CMD_FREE, 16'h0000, 16'd8 + 16'd32, 1'b0);
		queue_item(CMD_FREE, 16'h0000, 16'd8 + 16'd32, 1'b0);
		queue_item(CMD_FREE, 16'h0000, 16'(1024 + 8 + 5), 1'b0);
		queue_item(CMD_FREE, 16'h0000, 16'd8, 1'b0);
		queue_item(CMD_ALLOC, 16'd5000, 16'h0000, 1'b1);
		live_offsets.delete();
		queue_item(CMD_FREE, 16'h0000, 16'd8, 1'b0);
		queue_item(CMD_FREE, 16'h0000, 16'(32768 + 8), 1'b0);
		queue_item(CMD_FREE, 16'h0000, known_slot_offset(), 1'b0);

		// random: mostly allocate and free of live blocks
		for (int n = 0; n < 550; n++) begin
			p = $urandom_range(0, 99);
			if (live_offsets.size() == 0 || p < 50) begin
				queue_item(CMD_ALLOC, rand_size(), 16'($urandom), n == 300);
			end else if (p < 88) begin
				k = $urandom_range(0, live_offsets.size() - 1);
				off = live_offsets[k];
				live_offsets.delete(k);
				queue_item(CMD_FREE, 16'($urandom), off, n == 300);
			end else begin
				queue_item(CMD_FREE, 16'($urandom), known_slot_offset(), n == 300);
			end
		end
		gen_done = 1'b1;
	end

	initial begin
		fail_count = 0;
		sent_count = 0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	initial begin
		in_valid = 1'b0;
		cmd = CMD_ALLOC;
		request_size = '0;
		free_offset = '0;
		out_ready = 1'b0;
		in_taken = 1'b0;
	end

	always @(posedge clk)
		in_taken = in_valid && in_ready;

	// input driver
	always @(negedge clk) begin
		static int gap_left = 0;
		alloc_req_t r;
		logic nxt_valid;
		nxt_valid = in_valid;
		if (arst_n && !(in_valid && !in_taken)) begin
			nxt_valid = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_reqs.size() > 0 &&
					!(pending_reqs[0].drain_first && sent_count != recv_count)) begin
				r = pending_reqs.pop_front();
				gap_left = r.gap;
				cmd <= r.cmd;
				request_size <= r.size;
				free_offset <= r.offset;
				nxt_valid = 1'b1;
				sent_count++;
			end
		end
		in_valid <= nxt_valid;
	end

	// output ready with random stalls and one long hold-off
	always @(negedge clk) begin
		static int stall_left = 0;
		static bit held = 1'b0;
		int p;
		if (!held && sent_count >= 150) begin
			held = 1'b1;
			stall_left = HOLD_LEN;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			p = $urandom_range(0, 99);
			if (p < 70)
				out_ready <= 1'b1;
			else if (p < 96) begin
				stall_left = $urandom_range(0, 3);
				out_ready <= 1'b0;
			end else begin
				stall_left = $urandom_range(10, 60);
				out_ready <= 1'b0;
			end
		end
	end

	// response checker
	always @(posedge clk) begin
		alloc_resp_t e;
		if (arst_n && out_valid && out_ready) begin
			recv_count++;
			if (expected_resps.size() == 0) begin
				$display("%0t: unexpected item status=%0d data_offset=%0d",
					$realtime, status, data_offset);
				fail_count++;
			end else begin
				e = expected_resps.pop_front();
				if (status !== e.status) begin
					$display("%0t: status expected %0d actual %0d",
						$realtime, e.status, status);
					fail_count++;
				end
				if (data_offset !== e.data_offset) begin
					$display("%0t: data_offset expected %0d actual %0d",
						$realtime, e.data_offset, data_offset);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		static int idle_cycles = 0;
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WDOG_LIMIT) begin
			$display("[buddy_block_allocator] ERROR");
			$finish;
		end
	end

	// end of run
	initial begin
		wait (gen_done);
		wait (pending_reqs.size() == 0 && !in_valid && expected_resps.size() == 0);
		repeat (200) @(posedge clk);
		if (fail_count == 0 && expected_resps.size() == 0)
			$display("[buddy_block_allocator] OK");
		else
			$display("[buddy_block_allocator] ERROR");
		$finish;
	end

endmodule

>>> buddy_block_allocator.f
hw/rtl/bba_pkg.sv
hw/rtl/bba_ram.sv
hw/rtl/buddy_block_allocator.sv
tb/sv/tb.sv
